// ===== hdl/rlcs_pkg.sv =====
// Shared types and constants of the RGB linear contrast stretch.
// Used by every module of the block; depends on nothing.

package rlcs_pkg;

	localparam int NumLanes = 3;
	localparam int PixW     = 8;
	localparam int AmtW     = 9;
	localparam int QuoW     = 18;
	localparam int ProdW    = 20;
	localparam int ValW     = QuoW + 2;
	localparam int DivSteps = QuoW;
	localparam int CntW     = 5;

	localparam int TuserOpBit    = 0;
	localparam int TuserFirstBit = 1;

	typedef logic [PixW-1:0] pix_t;

	localparam pix_t PixMax = {PixW{1'b1}};

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_APPLY   = 1'b1
	} op_t;

	// Commands from the top level to each lane.
	typedef struct packed {
		logic measure;
		logic apply;
		logic first;
		logic take;
	} lane_ctrl_t;

	// Status from each lane to the top level and the merge stage.
	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

endpackage

// ===== hdl/rgb_linear_contrast_stretch.sv =====
// Top level of the RGB linear min/max contrast stretch.
// Depends on rlcs_pkg, rlcs_lane and rlcs_merge.
//
// Usage:
//   Stream a frame twice on the s_ channel. Measure items (s_tuser operation
//   bit 0) update the per-channel min and max and produce no output; set the
//   first bit on the first pixel of a frame to restart the statistics.
//   Apply items (operation bit 1) map each channel to
//   (p - min) * (max - min + 2 * amount) / (max - min) + min, truncated
//   toward zero and clamped to 0..255, and produce one m_ item. A channel
//   whose max equals its min passes through unchanged.
//   Write contrast_amount (signed) with cfg_we while the block is idle.
// Timing: a measure item leaves the lanes free for the next item. An apply
//   item holds the lanes through a multiply state, the bit-serial divide and
//   a done state, where it waits until the output register can take the
//   result; the next item is taken only after that. The output register is
//   loaded from the done state and drives m_tvalid.
// Reset: arst_n clears the amount to 0, min to 255 and max to 0 per channel.
// Stall: a result waits in the output register while m_tready is low; the next
//   item is still taken, and a further result waits in the lanes, s_tready low.

module rgb_linear_contrast_stretch import rlcs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [AmtW-1:0]              contrast_amount,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [NumLanes*PixW-1:0]     s_tdata,   // red, green, blue
	input  logic [1:0]                   s_tuser,   // operation, first
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [NumLanes*PixW-1:0]     m_tdata    // out_red, out_green, out_blue
);

	logic signed [AmtW-1:0]    amount_q;
	logic                      accept;
	op_t                       op;
	logic                      take;
	lane_ctrl_t                ctrl;
	lane_stat_t [NumLanes-1:0] stat;
	pix_t [NumLanes-1:0]       lane_res;
	logic [NumLanes-1:0]       idle;

	// Hold the contrast amount; the user must write it only while idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
		end else if (cfg_we) begin
			amount_q <= $signed(contrast_amount);
		end
	end

	assign accept = s_tvalid && s_tready;
	assign op     = op_t'(s_tuser[TuserOpBit]);

	// All lanes run in lockstep and see the same commands.
	assign ctrl.measure = accept && (op == OP_MEASURE);
	assign ctrl.apply   = accept && (op == OP_APPLY);
	assign ctrl.first   = s_tuser[TuserFirstBit];
	assign ctrl.take    = take;

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		rlcs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.pixel  (s_tdata[g*PixW +: PixW]),
			.amount (amount_q),
			.stat   (stat[g]),
			.result (lane_res[g])
		);
		assign idle[g] = stat[g].idle;
	end

	// Accept only while every lane is free of work and of a held result.
	assign s_tready = &idle;

	rlcs_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.lane_res (lane_res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.take     (take)
	);

endmodule

// ===== hdl/rlcs_lane.sv =====
// One color channel: running min/max statistics and the stretch datapath
// with a bit-serial restoring divider. Depends on rlcs_pkg.

module rlcs_lane import rlcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lane_ctrl_t             ctrl,
	input  pix_t                   pixel,
	input  logic signed [AmtW-1:0] amount,
	output lane_stat_t             stat,
	output pix_t                   result
);

	typedef enum logic [1:0] {
		IDLE,
		MUL,
		DIV,
		DONE
	} state_t;

	state_t           state_q;
	logic [CntW-1:0]  cnt_q;
	pix_t             min_q;
	pix_t             max_q;

	pix_t             p_q;
	logic             flat_q;
	logic             neg_q;
	logic [QuoW-1:0]  num_q;
	pix_t             rem_q;
	pix_t             dvs_q;

	logic signed [PixW:0]   diff;
	logic signed [PixW:0]   span;
	logic signed [AmtW+1:0] factor;
	logic signed [ProdW-1:0] prod;
	logic [ProdW-1:0]       prod_mag;
	logic [PixW:0]          span_mag;
	logic [PixW:0]          rem_sh;
	logic [PixW+1:0]        trial;
	logic                   qbit;
	pix_t                   rem_nx;
	logic signed [QuoW:0]   quo_s;
	logic signed [ValW-1:0] val;
	pix_t                   clamped;

	// Multiply stage: (p - min) * (span + 2 * amount), then sign and magnitude.
	always_comb begin
		diff     = $signed({1'b0, p_q}) - $signed({1'b0, min_q});
		span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		factor   = $signed({{2{span[PixW]}}, span}) +
		           $signed({amount[AmtW-1], amount, 1'b0});
		prod     = ProdW'(diff) * ProdW'(factor);
		prod_mag = prod[ProdW-1] ? unsigned'(-prod) : unsigned'(prod);
		span_mag = span[PixW] ? unsigned'(-span) : unsigned'(span);
	end

	// One quotient bit per cycle.
	always_comb begin
		rem_sh = {rem_q, num_q[QuoW-1]};
		trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit   = !trial[PixW+1];
		rem_nx = qbit ? trial[PixW-1:0] : rem_sh[PixW-1:0];
	end

	// Restore sign (truncation toward zero), add min, clamp to byte or pass p.
	always_comb begin
		quo_s = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
		val   = ValW'(quo_s) + $signed({{(ValW-PixW){1'b0}}, min_q});
		if (val[ValW-1]) begin
			clamped = '0;
		end else if (|val[ValW-2:PixW]) begin
			clamped = PixMax;
		end else begin
			clamped = val[PixW-1:0];
		end
		result = flat_q ? p_q : clamped;
	end

	assign stat.idle = (state_q == IDLE);
	assign stat.done = (state_q == DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (ctrl.apply) begin
						state_q <= MUL;
					end
				end
				MUL: begin
					state_q <= DIV;
					cnt_q   <= '0;
				end
				DIV: begin
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DONE: begin
					if (ctrl.take) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Statistics: the first flag restarts from this pixel alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= PixMax;
			max_q <= '0;
		end else if (ctrl.measure) begin
			if (ctrl.first) begin
				min_q <= pixel;
				max_q <= pixel;
			end else begin
				if (pixel < min_q) begin
					min_q <= pixel;
				end
				if (pixel > max_q) begin
					max_q <= pixel;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && ctrl.apply) begin
			p_q <= pixel;
		end
		if (state_q == MUL) begin
			num_q  <= prod_mag[QuoW-1:0];
			dvs_q  <= span_mag[PixW-1:0];
			rem_q  <= '0;
			neg_q  <= prod[ProdW-1] ^ span[PixW];
			flat_q <= (span == '0);
		end
		if (state_q == DIV) begin
			num_q <= {num_q[QuoW-2:0], qbit};
			rem_q <= rem_nx;
		end
	end

endmodule

// ===== hdl/rlcs_merge.sv =====
// Merge stage: collects the three lane results into one output item and
// holds it in the output register until taken. Depends on rlcs_pkg.

module rlcs_merge import rlcs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lane_stat_t [NumLanes-1:0]    stat,
	input  pix_t [NumLanes-1:0]          lane_res,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [NumLanes*PixW-1:0]     m_tdata,
	output logic                         take
);

	logic                     m_tvalid_q;
	logic [NumLanes*PixW-1:0] m_tdata_q;
	logic                     all_done;

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < NumLanes; i++) begin
			all_done = all_done & stat[i].done;
		end
	end

	// Load when every lane is done and the register is empty or draining.
	assign take     = all_done && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= lane_res;
		end
	end

endmodule

// ===== hdl/rlcs_checker.sv =====
// Port-level checks for rgb_linear_contrast_stretch, bound to the top level.
// Depends on rlcs_pkg.

module rlcs_checker import rlcs_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [1:0]               s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [NumLanes*PixW-1:0] m_tdata
);

	// A stalled output item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// An apply item occupies the lanes in the next cycle.
	a_apply_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[TuserOpBit] |=> !s_tready)
		else $error("input ready right after an apply item");

	// A measure item leaves the lanes free for the next cycle.
	a_measure_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[TuserOpBit] |=> s_tready)
		else $error("input not ready after a measure item");

	// A new output item needs an apply item accepted well before it.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output item without work in the lanes");

	// The amount changes only while nothing is in flight.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_tready && !m_tvalid)
		else $error("amount written while items are in flight");

endmodule

bind rgb_linear_contrast_stretch rlcs_checker u_rlcs_checker (.*);

// ===== tb/rgb_linear_contrast_stretch_tb.sv =====
// Testbench for rgb_linear_contrast_stretch: drives measure and apply frames,
// predicts each stretched pixel and checks every result item field by field.
// Depends on rlcs_pkg and the RTL of the block only.

module rgb_linear_contrast_stretch_tb;
	import rlcs_pkg::*;

	// One pending pixel item for the s_ channel.
	typedef struct {
		op_t  op;
		logic first;
		pix_t red;
		pix_t green;
		pix_t blue;
	} pixel_item_t;

	// Number of cycles to let pass once the block looks idle; long enough for an
	// apply item to leave the lanes.
	localparam int SettleCycles = 30;
	localparam int MaxPrinted   = 40;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     cfg_we         = 1'b0;
	logic [AmtW-1:0]          contrast_amount = '0;
	logic                     s_tvalid       = 1'b0;
	logic                     s_tready;
	logic [NumLanes*PixW-1:0] s_tdata        = '0;   // red, green, blue
	logic [1:0]               s_tuser        = '0;   // operation, first
	logic                     m_tvalid;
	logic                     m_tready       = 1'b0;
	logic [NumLanes*PixW-1:0] m_tdata;               // out_red, out_green, out_blue

	// Pixels waiting to be driven, and stretched pixels waiting to come out.
	pixel_item_t              pixel_q[$];
	logic [NumLanes*PixW-1:0] stretched_q[$];

	// Predictor state: running per-channel statistics and the signed amount.
	pix_t  lane_min[NumLanes] = '{PixMax, PixMax, PixMax};
	pix_t  lane_max[NumLanes] = '{8'd0, 8'd0, 8'd0};
	int    stretch_amount = 0;

	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	logic  took_item      = 1'b0;
	int    mismatch_count = 0;
	string lane_name[NumLanes] = '{"out_red", "out_green", "out_blue"};

	rgb_linear_contrast_stretch uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.contrast_amount (contrast_amount),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Print one line per mismatch; keep the log short on a badly broken block.
	task automatic report_mismatch(string msg);
		if (mismatch_count < MaxPrinted) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Map one channel through the min/max stretch. A flat channel passes
	// through; otherwise divide with sign, truncating toward zero, and clamp.
	function automatic pix_t stretch_lane(pix_t p, pix_t lo, pix_t hi);
		int span;
		int v;
		span = int'(hi) - int'(lo);
		if (span == 0) begin
			return p;
		end
		v = (int'(p) - int'(lo)) * (span + 2 * stretch_amount) / span + int'(lo);
		if (v < 0) begin
			v = 0;
		end
		if (v > int'(PixMax)) begin
			v = int'(PixMax);
		end
		return pix_t'(v);
	endfunction

	// Fold an accepted item into the statistics, or queue its stretched pixel.
	task automatic predict_pixel(logic [1:0] kind, logic [NumLanes*PixW-1:0] px);
		pix_t                     ch[NumLanes];
		logic [NumLanes*PixW-1:0] stretched;
		for (int c = 0; c < NumLanes; c++) begin
			ch[c] = px[c*PixW +: PixW];
		end
		if (op_t'(kind[TuserOpBit]) == OP_MEASURE) begin
			// Restart the statistics on the first pixel of a frame.
			if (kind[TuserFirstBit]) begin
				for (int c = 0; c < NumLanes; c++) begin
					lane_min[c] = PixMax;
					lane_max[c] = '0;
				end
			end
			for (int c = 0; c < NumLanes; c++) begin
				if (ch[c] > lane_max[c]) begin
					lane_max[c] = ch[c];
				end
				if (ch[c] < lane_min[c]) begin
					lane_min[c] = ch[c];
				end
			end
		end else begin
			// The first flag means nothing on an apply item.
			for (int c = 0; c < NumLanes; c++) begin
				stretched[c*PixW +: PixW] = stretch_lane(ch[c], lane_min[c], lane_max[c]);
			end
			stretched_q.push_back(stretched);
		end
	endtask

	// Driver: change inputs at the falling edge. Hold an item until the edge
	// that took it, then present the next one or idle at random.
	always @(negedge clk) begin : drive_pixels
		pixel_item_t nxt_pix;
		logic [1:0]  kind;
		if (arst_n && (!s_tvalid || took_item)) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt_pix = pixel_q.pop_front();
				kind[TuserOpBit]    = nxt_pix.op;
				kind[TuserFirstBit] = nxt_pix.first;
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt_pix.blue, nxt_pix.green, nxt_pix.red};
				s_tuser  <= kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: sample both handshakes at the rising edge. Predict first so an
	// expectation always exists before its result could be checked.
	always @(posedge clk) begin : watch_ports
		logic [NumLanes*PixW-1:0] want;
		took_item <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			predict_pixel(s_tuser, s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (stretched_q.size() == 0) begin
				report_mismatch($sformatf("result %h with no pixel expected", m_tdata));
			end else begin
				want = stretched_q.pop_front();
				for (int c = 0; c < NumLanes; c++) begin
					if (m_tdata[c*PixW +: PixW] !== want[c*PixW +: PixW]) begin
						report_mismatch($sformatf("%s got %0d, want %0d", lane_name[c],
							m_tdata[c*PixW +: PixW], want[c*PixW +: PixW]));
					end
				end
			end
		end
	end

	task automatic push_pixel(op_t op, logic first, pix_t r, pix_t g, pix_t b);
		pixel_item_t it;
		it.op    = op;
		it.first = first;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		pixel_q.push_back(it);
	endtask

	// Wait for all items to go in and all results to come out, then let the
	// lanes settle. Sample at the rising edge, where queues and valid are stable.
	task automatic wait_quiet();
		while (pixel_q.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (stretched_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write the signed amount while the block is idle.
	task automatic write_amount(int amt);
		@(negedge clk);
		cfg_we          <= 1'b1;
		contrast_amount <= amt[AmtW-1:0];
		stretch_amount   = amt;
		@(negedge clk);
		cfg_we          <= 1'b0;
	endtask

	// Queue one frame: a measure pass over pixels drawn from a per-channel
	// window (width zero gives a flat channel), then an apply pass of the same
	// length, mostly inside the window, sometimes anywhere. Now and then mix in
	// a stray item to break the frame.
	task automatic queue_frame(int npix);
		pix_t base[NumLanes];
		int   width[NumLanes];
		pix_t ch[NumLanes];
		for (int c = 0; c < NumLanes; c++) begin
			case ($urandom_range(3))
				0: width[c] = 0;
				1: width[c] = $urandom_range(1, 8);
				default: width[c] = $urandom_range(255);
			endcase
			base[c] = pix_t'($urandom_range(255 - width[c]));
		end
		for (int k = 0; k < npix; k++) begin
			for (int c = 0; c < NumLanes; c++) begin
				ch[c] = pix_t'(base[c] + $urandom_range(width[c]));
			end
			push_pixel(OP_MEASURE, k == 0, ch[0], ch[1], ch[2]);
		end
		for (int k = 0; k < npix; k++) begin
			for (int c = 0; c < NumLanes; c++) begin
				if ($urandom_range(3) == 0) begin
					ch[c] = pix_t'($urandom_range(255));
				end else begin
					ch[c] = pix_t'(base[c] + $urandom_range(width[c]));
				end
			end
			push_pixel(OP_APPLY, 1'($urandom_range(1)), ch[0], ch[1], ch[2]);
			if ($urandom_range(15) == 0) begin
				push_pixel(op_t'($urandom_range(1)), 1'($urandom_range(1)),
					pix_t'($urandom_range(255)), pix_t'($urandom_range(255)),
					pix_t'($urandom_range(255)));
			end
		end
	endtask

	// One random phase: set the amount and the idling, queue frames, drain.
	// Mostly short frames, with an occasional long one.
	task automatic run_phase(int amt, int send_pct, int recv_pct, int nitems);
		int queued;
		int npix;
		write_amount(amt);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queued = 0;
		while (queued < nitems) begin
			npix = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
			queue_frame(npix);
			queued += 2 * npix;
		end
		wait_quiet();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: apply on reset statistics, full and flat ranges, clamping,
		// the first flag on apply items, alternating bit patterns.
		write_amount(37);
		push_pixel(OP_APPLY,   1'b1, 8'd0,   8'd255, 8'd128);
		push_pixel(OP_APPLY,   1'b0, 8'd255, 8'd0,   8'd1);
		push_pixel(OP_MEASURE, 1'b1, 8'd0,   8'd0,   8'd0);
		push_pixel(OP_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
		push_pixel(OP_APPLY,   1'b0, 8'd0,   8'd255, 8'd128);
		push_pixel(OP_APPLY,   1'b0, 8'd1,   8'd254, 8'd200);
		push_pixel(OP_MEASURE, 1'b1, 8'd10,  8'd200, 8'd77);
		push_pixel(OP_MEASURE, 1'b0, 8'd10,  8'd100, 8'd77);
		push_pixel(OP_APPLY,   1'b0, 8'd10,  8'd150, 8'd77);
		push_pixel(OP_APPLY,   1'b0, 8'd0,   8'd255, 8'd3);
		push_pixel(OP_APPLY,   1'b1, 8'd255, 8'd99,  8'd255);
		push_pixel(OP_MEASURE, 1'b1, 8'h55,  8'hAA,  8'h0F);
		push_pixel(OP_MEASURE, 1'b0, 8'hAA,  8'h55,  8'hF0);
		push_pixel(OP_APPLY,   1'b0, 8'h55,  8'hAA,  8'h0F);
		push_pixel(OP_APPLY,   1'b0, 8'hAA,  8'h55,  8'hF0);
		push_pixel(OP_APPLY,   1'b0, 8'h80,  8'h7F,  8'h00);
		wait_quiet();

		// Random phases; each drain is a full sender pause until all results
		// are back.
		run_phase(255,  0,  0,  210);
		run_phase(-256, 55, 0,  210);
		run_phase(-255, 0,  55, 210);
		run_phase($urandom_range(511) - 256, 29, 29, 210);
		run_phase(0,    0,  0,  210);

		if (mismatch_count == 0 && stretched_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
